// File: src/set_assoc_lru_cache_tags_unit_assert.svh
// Assertion macros used by the checker.
// Each takes a label, a property expression and a message string.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define SALC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/salc_pkg.sv
`default_nettype none

package salc_pkg;

   localparam int unsigned ADDRESS_W   = 32;
   localparam int unsigned SET_NUM_W   = 6;
   localparam int unsigned COUNT_W     = 32;
   localparam int unsigned OFFSET_W    = 5;
   localparam int unsigned INDEX_W     = 3;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 5;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 5'd6;
   localparam logic [INDEX_W-1:0]  INDEX_RESET  = 3'd6;
   localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_BITS = 1'b0,
      CSR_INDEX_BITS  = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

// File: src/salc_channel_if.sv
`default_nettype none

// Address channel: one beat per memory access.
interface salc_req_if;
   logic                             valid;
   logic                             ready;
   logic [salc_pkg::ADDRESS_W-1:0]   address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

// Result channel: one beat per access.
interface salc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [salc_pkg::SET_NUM_W-1:0]   set_number;
   logic [salc_pkg::COUNT_W-1:0]     access_total;
   logic [salc_pkg::COUNT_W-1:0]     miss_total;

   modport source (output valid, output hit, output set_number, output access_total,
                   output miss_total, input ready);
   modport sink   (input valid, input hit, input set_number, input access_total,
                   input miss_total, output ready);
endinterface

`default_nettype wire

// File: src/set_assoc_lru_cache_tags_unit.sv
// Tag store of a set-associative cache with LRU replacement, counting accesses and misses.
// req_bus carries one byte address per beat; rsp_bus returns one beat per address:
// hit flag, set index, and saturating access and miss totals including this access.
// The csr_ port sets offset_bits (index 0) and index_bits (index 1); write only while idle.
// Pipeline: decode register, set-row read register, compare/update into the output
// register. An accepted beat passes through these in order and is offered on rsp_bus.
// Throughput is one address per cycle unless rsp_bus stalls, also for back-to-back hits
// on the same set: the row written back is forwarded to the next access reading that set.
// All ways of a set are one memory row, read once and written once per access.
// Reset (synchronous, active high) clears the counters and starts a clearing pass
// that zeroes every row of the tag memory, one row a cycle, 2**SET_BITS rows
// (two when SET_BITS is 0). req_bus.ready stays low until it ends; csr writes go on.
// A stalled rsp_bus holds its beat; the two pipeline registers ahead of it keep
// filling, so up to three accesses are held before req_bus.ready drops.

`default_nettype none

module set_assoc_lru_cache_tags_unit #(
   parameter int WAYS      = 4,
   parameter int SET_BITS  = 6,
   parameter int ADDR_BITS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   salc_req_if.sink                               req_bus,
   salc_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_wr_en,
   input  wire logic [salc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [salc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SIW      = (SET_BITS > 0) ? SET_BITS : 1;   // set index width
   localparam int NUM_ROWS = 1 << SIW;
   localparam int RW       = (WAYS > 1) ? $clog2(WAYS) : 1;  // rank and way index width
   localparam int IB_W     = 4;                              // clamped index width
   localparam int SHIFT_W  = 6;                              // offset + index shift

   localparam logic [IB_W-1:0] SET_BITS_IB = IB_W'(SET_BITS);
   localparam logic [RW-1:0]   LRU_RANK    = RW'(WAYS - 1);

   typedef struct packed {
      logic [WAYS-1:0]                valid;
      logic [WAYS-1:0][RW-1:0]        rank;
      logic [WAYS-1:0][ADDR_BITS-1:0] tag;
   } row_type;

   // Configuration
   logic [salc_pkg::OFFSET_W-1:0] offset_bits_ff, offset_bits_in;
   logic [salc_pkg::INDEX_W-1:0]  index_bits_ff, index_bits_in;

   // Clearing pass
   logic           clr_busy_ff, clr_busy_in;
   logic [SIW-1:0] clr_row_ff, clr_row_in;

   // Stage 1: decoded address
   logic                 s1_valid_ff, s1_valid_in;
   logic [SIW-1:0]       s1_set_ff, s1_set_in;
   logic [ADDR_BITS-1:0] s1_tag_ff, s1_tag_in;

   // Stage 2: row read, forwarding
   logic                 s2_valid_ff, s2_valid_in;
   logic [SIW-1:0]       s2_set_ff, s2_set_in;
   logic [ADDR_BITS-1:0] s2_tag_ff, s2_tag_in;
   logic                 fwd_hit_ff, fwd_hit_in;
   row_type              fwd_row_ff, fwd_row_in;
   row_type              rd_row_ff;

   // Output register and counters
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_hit_ff, rsp_hit_in;
   logic [salc_pkg::SET_NUM_W-1:0]    rsp_set_ff, rsp_set_in;
   logic [salc_pkg::COUNT_W-1:0]      acc_ff, acc_in;
   logic [salc_pkg::COUNT_W-1:0]      miss_ff, miss_in;

   row_type tag_mem [NUM_ROWS];

   // Handshake
   logic s2_adv, s2_load, s1_adv, s1_load, req_acc;

   // Decode
   logic [IB_W-1:0]      ib;
   logic [ADDR_BITS-1:0] addr_m;
   logic [ADDR_BITS-1:0] shifted;
   logic [SIW-1:0]       set_mask;
   logic [SIW-1:0]       set_dec;
   logic [ADDR_BITS-1:0] tag_dec;

   // Lookup
   row_type         row_cur;
   row_type         row_new;
   logic [WAYS-1:0] hit_vec, inv_vec, lru_vec;
   logic [RW-1:0]   hit_way, inv_way, lru_way, way_sel;
   logic            lookup_hit, any_inv, fill_all_age;
   logic [RW-1:0]   rank_sel;

   // Memory write port
   logic           mem_we;
   logic [SIW-1:0] mem_waddr;
   row_type        mem_wdata;

   assign s2_adv  = s2_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign s2_load = !s2_valid_ff || s2_adv;
   assign s1_adv  = s1_valid_ff && s2_load;
   assign s1_load = !s1_valid_ff || s1_adv;
   assign req_acc = req_bus.valid && req_bus.ready;

   assign req_bus.ready = !clr_busy_ff && s1_load;

   // Address split; shifts past the address width give zero.
   always_comb begin
      ib       = ({1'b0, index_bits_ff} > SET_BITS_IB) ? SET_BITS_IB : {1'b0, index_bits_ff};
      addr_m   = req_bus.address[ADDR_BITS-1:0];
      shifted  = addr_m >> offset_bits_ff;
      set_mask = ~({SIW{1'b1}} << ib);
      set_dec  = SIW'(shifted) & set_mask;
      tag_dec  = addr_m >> (SHIFT_W'(offset_bits_ff) + SHIFT_W'(ib));
   end

   // Way compare and LRU update for the set in stage 2.
   always_comb begin
      row_cur = fwd_hit_ff ? fwd_row_ff : rd_row_ff;
      hit_way = '0;
      inv_way = '0;
      lru_way = '0;
      for (int k = 0; k < WAYS; k++) begin
         hit_vec[k] = row_cur.valid[k] && (row_cur.tag[k] == s2_tag_ff);
         inv_vec[k] = !row_cur.valid[k];
         lru_vec[k] = row_cur.rank[k] == LRU_RANK;
      end
      // Lowest-numbered match wins.
      for (int k = WAYS - 1; k >= 0; k--) begin
         if (hit_vec[k]) begin
            hit_way = RW'(k);
         end
         if (inv_vec[k]) begin
            inv_way = RW'(k);
         end
         if (lru_vec[k]) begin
            lru_way = RW'(k);
         end
      end
      lookup_hit   = |hit_vec;
      any_inv      = |inv_vec;
      way_sel      = lookup_hit ? hit_way : (any_inv ? inv_way : lru_way);
      fill_all_age = !lookup_hit && any_inv;   // new line: every valid way ages
      rank_sel     = row_cur.rank[way_sel];

      row_new = row_cur;
      for (int k = 0; k < WAYS; k++) begin
         if (RW'(k) == way_sel) begin
            row_new.rank[k]  = '0;
            row_new.valid[k] = 1'b1;
            row_new.tag[k]   = s2_tag_ff;
         end else if (row_cur.valid[k] && (fill_all_age || (row_cur.rank[k] < rank_sel))) begin
            row_new.rank[k] = row_cur.rank[k] + 1'b1;
         end
      end
   end

   assign mem_we    = clr_busy_ff || s2_adv;
   assign mem_waddr = clr_busy_ff ? clr_row_ff : s2_set_ff;
   assign mem_wdata = clr_busy_ff ? row_type'('0) : row_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr] <= mem_wdata;
      end
      if (s1_adv) begin
         rd_row_ff <= tag_mem[s1_set_ff];
      end
   end

   // Next state
   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      if (csr_wr_en) begin
         case (csr_index)
            salc_pkg::CSR_OFFSET_BITS: begin
               offset_bits_in = csr_wdata[salc_pkg::OFFSET_W-1:0];
            end
            salc_pkg::CSR_INDEX_BITS: begin
               index_bits_in = csr_wdata[salc_pkg::INDEX_W-1:0];
            end
            default: begin
            end
         endcase
      end

      clr_busy_in = clr_busy_ff;
      clr_row_in  = clr_row_ff;
      if (clr_busy_ff) begin
         if (clr_row_ff == SIW'(NUM_ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_row_in = clr_row_ff + 1'b1;
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_set_in   = s1_set_ff;
      s1_tag_in   = s1_tag_ff;
      if (s1_load) begin
         s1_valid_in = req_acc;
      end
      if (req_acc) begin
         s1_set_in = set_dec;
         s1_tag_in = tag_dec;
      end

      s2_valid_in = s2_valid_ff;
      s2_set_in   = s2_set_ff;
      s2_tag_in   = s2_tag_ff;
      fwd_hit_in  = fwd_hit_ff;
      fwd_row_in  = fwd_row_ff;
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         s2_set_in  = s1_set_ff;
         s2_tag_in  = s1_tag_ff;
         // The row read at this edge misses the write-back at this same edge.
         fwd_hit_in = s2_adv && (s2_set_ff == s1_set_ff);
         fwd_row_in = row_new;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_set_in   = rsp_set_ff;
      acc_in       = acc_ff;
      miss_in      = miss_ff;
      if (s2_adv) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = lookup_hit;
         rsp_set_in   = salc_pkg::SET_NUM_W'(s2_set_ff);
         if (acc_ff != salc_pkg::COUNT_MAX) begin
            acc_in = acc_ff + 1'b1;
         end
         if (!lookup_hit && (miss_ff != salc_pkg::COUNT_MAX)) begin
            miss_in = miss_ff + 1'b1;
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= salc_pkg::OFFSET_RESET;
         index_bits_ff  <= salc_pkg::INDEX_RESET;
         clr_busy_ff    <= 1'b1;
         clr_row_ff     <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         acc_ff         <= '0;
         miss_ff        <= '0;
      end else begin
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         clr_busy_ff    <= clr_busy_in;
         clr_row_ff     <= clr_row_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         fwd_hit_ff     <= fwd_hit_in;
         rsp_valid_ff   <= rsp_valid_in;
         acc_ff         <= acc_in;
         miss_ff        <= miss_in;
      end
      s1_set_ff  <= s1_set_in;
      s1_tag_ff  <= s1_tag_in;
      s2_set_ff  <= s2_set_in;
      s2_tag_ff  <= s2_tag_in;
      fwd_row_ff <= fwd_row_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_set_ff <= rsp_set_in;
   end

   // Counters only move when a beat enters the output register.
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.set_number   = rsp_set_ff;
   assign rsp_bus.access_total = acc_ff;
   assign rsp_bus.miss_total   = miss_ff;

endmodule

`default_nettype wire

// File: src/salc_checker.sv
`default_nettype none

`include "set_assoc_lru_cache_tags_unit_assert.svh"

module salc_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_hit,
   input wire logic [salc_pkg::COUNT_W-1:0]   rsp_access_total,
   input wire logic [salc_pkg::COUNT_W-1:0]   rsp_miss_total
);

   // A stalled result beat stays offered.
   `SALC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")

   // Misses are a subset of accesses.
   `SALC_ASSERT(a_miss_le_acc, rsp_valid |-> rsp_miss_total <= rsp_access_total, "miss total above access total")

   // A miss beat counts itself.
   `SALC_ASSERT(a_miss_counted, rsp_valid && !rsp_hit |-> rsp_miss_total != '0, "miss beat with zero miss total")

   // Clearing pass blocks addresses right after reset.
   `SALC_ASSERT_ALWAYS(a_clear_after_reset, $past(reset) && !reset |-> !req_ready, "req ready during clearing pass")

endmodule

bind set_assoc_lru_cache_tags_unit salc_checker u_salc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_hit          (rsp_bus.hit),
   .rsp_access_total (rsp_bus.access_total),
   .rsp_miss_total   (rsp_bus.miss_total)
);

`default_nettype wire
